>>> hdl/pidca_pkg.sv
`timescale 1ns / 1ps
// pidca_pkg: shared types, constants and fixed-point helpers for the PID core
// no dependencies

package pidca_pkg;

    localparam int FRAC_BITS = 24;
    localparam int DATA_W    = 32;
    localparam int ILIM_W    = 31;
    localparam int REG_IDX_W = 3;

    typedef logic signed [DATA_W-1:0] word_t;

    localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam word_t WORD_ZERO = '0;

    typedef enum logic {
        CMD_RUN   = 1'b0,
        CMD_CLEAR = 1'b1
    } cmd_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_INTEG_GAIN  = 3'd1,
        REG_DERIV_GAIN  = 3'd2,
        REG_OUT_MIN     = 3'd3,
        REG_OUT_MAX     = 3'd4,
        REG_INTEG_LIMIT = 3'd5
    } reg_idx_t;

    typedef struct packed {
        word_t              prop_gain;
        word_t              integ_gain;
        word_t              deriv_gain;
        word_t              out_min;
        word_t              out_max;
        logic [ILIM_W-1:0]  integ_limit;
    } cfg_t;

    // error sample with its saturated difference to the previous sample
    typedef struct packed {
        logic  clr;
        word_t err;
        word_t diff;
    } front_t;

    typedef struct packed {
        logic  clr;
        word_t p;
        word_t d;
        word_t g;
    } prod_t;

    typedef struct packed {
        logic  clr;
        word_t p;
        word_t d;
        word_t acc;
    } integ_t;

    function automatic word_t sat64(input logic signed [2*DATA_W-1:0] v);
        word_t res;
        if ((&v[2*DATA_W-1:DATA_W-1]) || ~(|v[2*DATA_W-1:DATA_W-1])) begin
            res = v[DATA_W-1:0];
        end else if (v[2*DATA_W-1]) begin
            res = WORD_MIN;
        end else begin
            res = WORD_MAX;
        end
        return res;
    endfunction

    // product shifted right with floor rounding, then saturated
    function automatic word_t qmul(input word_t a, input word_t b);
        logic signed [2*DATA_W-1:0] prod;
        logic signed [2*DATA_W-1:0] shifted;
        prod = $signed({{DATA_W{a[DATA_W-1]}}, a}) * $signed({{DATA_W{b[DATA_W-1]}}, b});
        shifted = prod >>> FRAC_BITS;
        return sat64(shifted);
    endfunction

    function automatic word_t qadd(input word_t a, input word_t b);
        logic [DATA_W:0] s;
        word_t res;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            res = s[DATA_W] ? WORD_MIN : WORD_MAX;
        end else begin
            res = s[DATA_W-1:0];
        end
        return res;
    endfunction

    function automatic word_t qsub(input word_t a, input word_t b);
        logic [DATA_W:0] s;
        word_t res;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            res = s[DATA_W] ? WORD_MIN : WORD_MAX;
        end else begin
            res = s[DATA_W-1:0];
        end
        return res;
    endfunction

    function automatic word_t qclamp(input word_t x, input word_t lo, input word_t hi);
        word_t res;
        if (x < lo) begin
            res = lo;
        end else if (x > hi) begin
            res = hi;
        end else begin
            res = x;
        end
        return res;
    endfunction

endpackage

>>> hdl/pidca_in_if.sv
`timescale 1ns / 1ps
// pidca_in_if: input channel, error sample and command with valid/ready
// depends on pidca_pkg

interface pidca_in_if;
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    pidca_pkg::word_t           err_sample;

    modport source (output valid, output cmd, output err_sample, input ready);
    modport sink   (input valid, input cmd, input err_sample, output ready);
endinterface

>>> hdl/pidca_out_if.sv
`timescale 1ns / 1ps
// pidca_out_if: result channel, clamped drive value with valid/ready
// depends on pidca_pkg

interface pidca_out_if;
    logic                       valid;
    logic                       ready;
    pidca_pkg::word_t           drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

>>> hdl/pid_conditional_antiwindup_core.sv
`timescale 1ns / 1ps
// pid_conditional_antiwindup_core: PID controller with conditional-integration anti-windup
// depends on pidca_pkg, pidca_in_if, pidca_out_if, pidca_front, pidca_mult,
// pidca_integ, pidca_out
//
// channel   dir  handshake    payload
// in_ch     in   valid/ready  cmd, err_sample
// out_ch    out  valid/ready  drive
// cfg       in   cfg_we       cfg_idx, cfg_wdata (write only)
//
// one transfer per cycle sustained while out_ch.ready stays high
// rate is set by the integral register, updated once per item
// stages: input register, gain products, integrator, output clamp register
// each stage holds its item under backpressure and refills as soon as it empties
// reset clears all configuration, integral and error history to zero

module pid_conditional_antiwindup_core (
    input  logic                            clk,
    input  logic                            rst_n,
    pidca_in_if.sink                        in_ch,
    pidca_out_if.source                     out_ch,
    input  logic                            cfg_we,
    input  logic [pidca_pkg::REG_IDX_W-1:0] cfg_idx,
    input  logic [pidca_pkg::DATA_W-1:0]    cfg_wdata
);
    import pidca_pkg::*;

    cfg_t   cfg_reg;
    cfg_t   cfg_next;

    logic   f_valid;
    logic   f_ready;
    front_t f_data;
    logic   m_valid;
    logic   m_ready;
    prod_t  m_data;
    logic   i_valid;
    logic   i_ready;
    integ_t i_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_idx_t'(cfg_idx))
                REG_PROP_GAIN:   cfg_next.prop_gain   = cfg_wdata;
                REG_INTEG_GAIN:  cfg_next.integ_gain  = cfg_wdata;
                REG_DERIV_GAIN:  cfg_next.deriv_gain  = cfg_wdata;
                REG_OUT_MIN:     cfg_next.out_min     = cfg_wdata;
                REG_OUT_MAX:     cfg_next.out_max     = cfg_wdata;
                REG_INTEG_LIMIT: cfg_next.integ_limit = cfg_wdata[ILIM_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pidca_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .dn_valid (f_valid),
        .dn_ready (f_ready),
        .dn_data  (f_data)
    );

    pidca_mult u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .up_valid (f_valid),
        .up_ready (f_ready),
        .up_data  (f_data),
        .dn_valid (m_valid),
        .dn_ready (m_ready),
        .dn_data  (m_data)
    );

    pidca_integ u_integ (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .up_valid (m_valid),
        .up_ready (m_ready),
        .up_data  (m_data),
        .dn_valid (i_valid),
        .dn_ready (i_ready),
        .dn_data  (i_data)
    );

    pidca_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .up_valid (i_valid),
        .up_ready (i_ready),
        .up_data  (i_data),
        .out_ch   (out_ch)
    );

endmodule

>>> hdl/pidca_front.sv
`timescale 1ns / 1ps
// pidca_front: input register, error history and saturated error difference
// depends on pidca_pkg, pidca_in_if

module pidca_front (
    input  logic                clk,
    input  logic                rst_n,
    pidca_in_if.sink            in_ch,
    output logic                dn_valid,
    input  logic                dn_ready,
    output pidca_pkg::front_t   dn_data
);
    import pidca_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    word_t  prev_err_reg;
    word_t  prev_err_next;
    front_t data_reg;
    front_t data_next;
    logic   load;
    logic   is_clear;

    assign in_ch.ready = !valid_reg || dn_ready;
    assign load        = in_ch.valid && in_ch.ready;
    assign is_clear    = (in_ch.cmd == CMD_CLEAR);

    always_comb
    begin
        valid_next     = in_ch.ready ? in_ch.valid : valid_reg;
        prev_err_next  = load ? (is_clear ? WORD_ZERO : in_ch.err_sample) : prev_err_reg;
        data_next.clr  = is_clear;
        data_next.err  = in_ch.err_sample;
        data_next.diff = qsub(in_ch.err_sample, prev_err_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            prev_err_reg <= WORD_ZERO;
        end
        else
        begin
            valid_reg    <= valid_next;
            prev_err_reg <= prev_err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

>>> hdl/pidca_mult.sv
`timescale 1ns / 1ps
// pidca_mult: registered gain products for proportional, derivative, integral terms
// depends on pidca_pkg

module pidca_mult (
    input  logic                clk,
    input  logic                rst_n,
    input  pidca_pkg::cfg_t     cfg,
    input  logic                up_valid,
    output logic                up_ready,
    input  pidca_pkg::front_t   up_data,
    output logic                dn_valid,
    input  logic                dn_ready,
    output pidca_pkg::prod_t    dn_data
);
    import pidca_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    prod_t  data_reg;
    prod_t  data_next;
    logic   load;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    always_comb
    begin
        valid_next    = up_ready ? up_valid : valid_reg;
        data_next.clr = up_data.clr;
        data_next.p   = qmul(cfg.prop_gain, up_data.err);
        data_next.d   = qmul(cfg.deriv_gain, up_data.diff);
        data_next.g   = qmul(cfg.integ_gain, up_data.err);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

>>> hdl/pidca_integ.sv
`timescale 1ns / 1ps
// pidca_integ: integral accumulator with conditional integration and limit clamp
// depends on pidca_pkg

module pidca_integ (
    input  logic                clk,
    input  logic                rst_n,
    input  pidca_pkg::cfg_t     cfg,
    input  logic                up_valid,
    output logic                up_ready,
    input  pidca_pkg::prod_t    up_data,
    output logic                dn_valid,
    input  logic                dn_ready,
    output pidca_pkg::integ_t   dn_data
);
    import pidca_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    word_t  acc_reg;
    word_t  acc_next;
    integ_t data_reg;
    integ_t data_next;
    logic   load;
    word_t  cand;
    logic   in_range;
    word_t  lim_pos;
    word_t  lim_neg;
    word_t  acc_upd;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;
    assign lim_pos  = {1'b0, cfg.integ_limit};
    assign lim_neg  = -lim_pos;

    always_comb
    begin
        cand     = qadd(qadd(up_data.p, acc_reg), up_data.d);
        in_range = (cand >= cfg.out_min) && (cand <= cfg.out_max);
        acc_upd  = qclamp(qadd(acc_reg, up_data.g), lim_neg, lim_pos);
        if (up_data.clr)
        begin
            acc_next = WORD_ZERO;
        end
        else if (in_range)
        begin
            acc_next = acc_upd;
        end
        else
        begin
            acc_next = acc_reg;
        end
        valid_next    = up_ready ? up_valid : valid_reg;
        data_next.clr = up_data.clr;
        data_next.p   = up_data.p;
        data_next.d   = up_data.d;
        data_next.acc = acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            acc_reg   <= WORD_ZERO;
        end
        else
        begin
            valid_reg <= valid_next;
            if (load)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    a_clear_zeroes_acc: assert property (@(posedge clk) disable iff (!rst_n)
        load && up_data.clr |=> acc_reg == WORD_ZERO)
        else $error("integral not zero after clear");

    a_update_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        load && !up_data.clr && in_range |=>
            acc_reg <= $past(lim_pos) && acc_reg >= $past(lim_neg))
        else $error("integral outside its limit after update");

    a_hold_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        load && !up_data.clr && !in_range |=> acc_reg == $past(acc_reg))
        else $error("integral changed while candidate outside output limits");

endmodule

>>> hdl/pidca_out.sv
`timescale 1ns / 1ps
// pidca_out: final sum, output clamp and result register
// depends on pidca_pkg, pidca_out_if

module pidca_out (
    input  logic                clk,
    input  logic                rst_n,
    input  pidca_pkg::cfg_t     cfg,
    input  logic                up_valid,
    output logic                up_ready,
    input  pidca_pkg::integ_t   up_data,
    pidca_out_if.source         out_ch
);
    import pidca_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    word_t  drive_reg;
    word_t  drive_next;
    logic   load;

    assign up_ready = !valid_reg || out_ch.ready;
    assign load     = up_valid && up_ready;

    always_comb
    begin
        valid_next = up_ready ? up_valid : valid_reg;
        if (up_data.clr)
        begin
            drive_next = WORD_ZERO;
        end
        else
        begin
            drive_next = qclamp(qadd(qadd(up_data.p, up_data.acc), up_data.d),
                                cfg.out_min, cfg.out_max);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            drive_reg <= drive_next;
        end
    end

    assign out_ch.valid = valid_reg;
    assign out_ch.drive = drive_reg;

    a_clear_drive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        load && up_data.clr |=> drive_reg == WORD_ZERO)
        else $error("drive not zero after clear");

    a_drive_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
        load && !up_data.clr && (cfg.out_min <= cfg.out_max) |=>
            drive_reg >= $past(cfg.out_min) && drive_reg <= $past(cfg.out_max))
        else $error("drive outside output limits");

endmodule

>>> tb/sv/pid_conditional_antiwindup_core_test.sv
`timescale 1ns / 1ps
// pid_conditional_antiwindup_core_test: self-checking bench for the PID core with
// conditional-integration anti-windup; predicts each drive value and compares it
// depends on pidca_pkg, pidca_in_if, pidca_out_if, pid_conditional_antiwindup_core

module pid_conditional_antiwindup_core_test;
    import pidca_pkg::*;

    localparam word_t ONE_Q        = 32'sd16777216;
    localparam int    CFG_PAUSE    = 8;
    localparam int    HOLD_CYCLES  = 300;
    localparam int    PHASES       = 6;
    localparam int    PHASE_ITEMS  = 300;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic [DATA_W-1:0]    cfg_wdata;

    pidca_in_if  in_ch ();
    pidca_out_if out_ch ();

    pid_conditional_antiwindup_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    // predictor copy of the configuration and controller state
    word_t             pred_kp;
    word_t             pred_ki;
    word_t             pred_kd;
    word_t             pred_lo;
    word_t             pred_hi;
    logic [ILIM_W-1:0] pred_lim;
    word_t             integ_state;
    word_t             last_err;

    word_t expected_drive[$];

    int error_count;
    int step_count;
    int clear_count;
    int setting_count;
    int longest_hold;
    bit tx_gaps;
    bit rx_stalls;
    bit hold_req;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("timeout: %0d results still pending", expected_drive.size());
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic word_t sat_word(input longint v);
        word_t res;
        if (v > longint'(WORD_MAX)) begin
            res = WORD_MAX;
        end else if (v < longint'(WORD_MIN)) begin
            res = WORD_MIN;
        end else begin
            res = word_t'(v);
        end
        return res;
    endfunction

    function automatic word_t mul_q(input word_t a, input word_t b);
        longint prod;
        prod = longint'(a) * longint'(b);
        return sat_word(prod >>> FRAC_BITS);
    endfunction

    function automatic word_t add_sat(input word_t a, input word_t b);
        return sat_word(longint'(a) + longint'(b));
    endfunction

    function automatic word_t sub_sat(input word_t a, input word_t b);
        return sat_word(longint'(a) - longint'(b));
    endfunction

    function automatic word_t limit_to(input word_t x, input word_t lo, input word_t hi);
        word_t res;
        if (x < lo) begin
            res = lo;
        end else if (x > hi) begin
            res = hi;
        end else begin
            res = x;
        end
        return res;
    endfunction

    function automatic word_t pid_drive_step(input cmd_t c, input word_t e);
        word_t p;
        word_t d;
        word_t cand;
        word_t lim_w;
        if (c == CMD_CLEAR) begin
            integ_state = WORD_ZERO;
            last_err    = WORD_ZERO;
            return WORD_ZERO;
        end
        lim_w = word_t'({1'b0, pred_lim});
        p     = mul_q(pred_kp, e);
        d     = mul_q(pred_kd, sub_sat(e, last_err));
        cand  = add_sat(add_sat(p, integ_state), d);
        if (cand >= pred_lo && cand <= pred_hi) begin
            integ_state = limit_to(add_sat(integ_state, mul_q(pred_ki, e)), -lim_w, lim_w);
        end
        last_err = e;
        return limit_to(add_sat(add_sat(p, integ_state), d), pred_lo, pred_hi);
    endfunction

    function automatic int pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic word_t rand_err();
        case ($urandom_range(0, 9))
            0:       return ($urandom_range(0, 1) != 0) ? WORD_MAX : WORD_MIN;
            1, 2:    return word_t'($urandom);
            default: return word_t'(int'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
        endcase
    endfunction

    function automatic word_t rand_gain();
        case ($urandom_range(0, 7))
            0:       return word_t'($urandom);
            1:       return ($urandom_range(0, 1) != 0) ? WORD_MAX : WORD_MIN;
            default: return word_t'(int'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // receiver side: random stalls, or one long hold-off on request
    initial begin
        int stall_left;
        int held;
        stall_left   = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(negedge clk);
                    held++;
                end
                if (held > longest_hold) longest_hold = held;
                hold_req = 1'b0;
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if (rx_stalls && $urandom_range(0, 99) < 25) begin
                out_ch.ready <= 1'b0;
                stall_left = (pick_delay() > 3) ? $urandom_range(19, 59) : $urandom_range(0, 2);
                if (stall_left + 1 > longest_hold) longest_hold = stall_left + 1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // result checker
    initial begin
        word_t want;
        forever begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready) begin
                if (expected_drive.size() == 0) begin
                    report_mismatch("drive with no transfer pending", out_ch.drive, WORD_ZERO);
                end else begin
                    want = expected_drive.pop_front();
                    if (out_ch.drive !== want) begin
                        report_mismatch("drive", out_ch.drive, want);
                    end
                end
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_sample(input cmd_t c, input word_t e);
        int gap;
        gap = tx_gaps ? pick_delay() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.cmd        <= c;
        in_ch.err_sample <= e;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        expected_drive.push_back(pid_drive_step(c, e));
        if (c == CMD_CLEAR) clear_count++;
        else step_count++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_drive.size() != 0) @(negedge clk);
        repeat (CFG_PAUSE) @(negedge clk);
    endtask

    task automatic load_settings(input word_t kp, input word_t ki, input word_t kd,
                                 input word_t lo, input word_t hi, input logic [31:0] lim);
        reg_idx_t    idx [6];
        logic [31:0] val [6];
        wait_idle();
        idx = '{REG_PROP_GAIN, REG_INTEG_GAIN, REG_DERIV_GAIN,
                REG_OUT_MIN, REG_OUT_MAX, REG_INTEG_LIMIT};
        val = '{kp, ki, kd, lo, hi, lim};
        for (int i = 0; i < 6; i++) begin
            cfg_we    <= 1'b1;
            cfg_idx   <= idx[i];
            cfg_wdata <= val[i];
            @(negedge clk);
        end
        cfg_we   <= 1'b0;
        pred_kp  = kp;
        pred_ki  = ki;
        pred_kd  = kd;
        pred_lo  = lo;
        pred_hi  = hi;
        pred_lim = lim[ILIM_W-1:0];
        setting_count++;
    endtask

    task automatic test_reset_values();
        send_sample(CMD_RUN, WORD_MAX);
        send_sample(CMD_RUN, WORD_MIN);
    endtask

    task automatic test_field_extremes();
        load_settings(ONE_Q, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX, 32'hFFFF_FFFF);
        send_sample(CMD_RUN, WORD_MAX);
        send_sample(CMD_RUN, WORD_MIN);
        send_sample(CMD_RUN, WORD_MAX);
        send_sample(CMD_RUN, WORD_ZERO);
        send_sample(CMD_RUN, -32'sd1);
        send_sample(CMD_RUN, 32'sd1);
        load_settings(WORD_MIN, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, 32'h7FFF_FFFF);
        send_sample(CMD_RUN, WORD_MIN);
        send_sample(CMD_RUN, WORD_MAX);
        send_sample(CMD_RUN, -32'sd1);
    endtask

    task automatic test_clear();
        load_settings(ONE_Q, ONE_Q, ONE_Q, -32'sd100_000_000, 32'sd100_000_000, 32'd50_000_000);
        send_sample(CMD_RUN, 32'sd30_000_000);
        send_sample(CMD_CLEAR, WORD_MAX);
        send_sample(CMD_RUN, 32'sd30_000_000);
        send_sample(CMD_CLEAR, WORD_MIN);
        send_sample(CMD_RUN, -32'sd5);
    endtask

    task automatic test_inverted_limits();
        load_settings(ONE_Q, ONE_Q, WORD_ZERO, 32'sd100, -32'sd100, 32'd1000);
        send_sample(CMD_RUN, 32'sd50);
        send_sample(CMD_RUN, -32'sd500);
        send_sample(CMD_RUN, 32'sd500);
    endtask

    task automatic test_zero_integ_limit();
        load_settings(WORD_ZERO, WORD_MAX, WORD_ZERO, WORD_MIN, WORD_MAX, 32'h8000_0000);
        send_sample(CMD_RUN, 32'sd1000);
        send_sample(CMD_RUN, WORD_MIN);
        send_sample(CMD_RUN, WORD_MAX);
    endtask

    task automatic random_settings();
        word_t a;
        word_t b;
        word_t t;
        logic [31:0] lim;
        a = rand_err();
        b = rand_err();
        if (a > b && $urandom_range(0, 9) != 0) begin
            t = a;
            a = b;
            b = t;
        end
        if ($urandom_range(0, 7) == 0) begin
            a = WORD_MIN;
            b = WORD_MAX;
        end
        case ($urandom_range(0, 5))
            0:       lim = 32'h0;
            1:       lim = $urandom;
            default: lim = {$urandom_range(0, 1) == 1, 31'($urandom_range(0, 32'h0800_0000))};
        endcase
        load_settings(rand_gain(), rand_gain(), rand_gain(), a, b, lim);
    endtask

    task automatic test_random_steps();
        int left;
        int burst;
        word_t e;
        for (int ph = 0; ph < PHASES; ph++) begin
            random_settings();
            tx_gaps   = (ph % 3) != 2;
            rx_stalls = (ph % 3) != 1;
            left      = PHASE_ITEMS;
            while (left > 0) begin
                case ($urandom_range(0, 9))
                    0: begin
                        send_sample(CMD_CLEAR, word_t'($urandom));
                        left--;
                    end
                    1, 2: begin
                        // held error drives the output into its limits
                        e     = rand_err();
                        burst = $urandom_range(10, 30);
                        for (int k = 0; k < burst && left > 0; k++) begin
                            send_sample(CMD_RUN, e);
                            left--;
                        end
                        send_sample(CMD_RUN, -e);
                        left--;
                    end
                    default: begin
                        send_sample(CMD_RUN, rand_err());
                        left--;
                    end
                endcase
            end
        end
    endtask

    task automatic test_output_hold();
        random_settings();
        tx_gaps  = 1'b0;
        hold_req = 1'b1;
        for (int k = 0; k < 40; k++) begin
            send_sample(CMD_RUN, rand_err());
        end
        tx_gaps = 1'b1;
    endtask

    initial begin
        int guard;
        error_count   = 0;
        step_count    = 0;
        clear_count   = 0;
        setting_count = 0;
        longest_hold  = 0;
        tx_gaps       = 1'b1;
        rx_stalls     = 1'b1;
        hold_req      = 1'b0;
        pred_kp       = WORD_ZERO;
        pred_ki       = WORD_ZERO;
        pred_kd       = WORD_ZERO;
        pred_lo       = WORD_ZERO;
        pred_hi       = WORD_ZERO;
        pred_lim      = '0;
        integ_state   = WORD_ZERO;
        last_err      = WORD_ZERO;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= REG_PROP_GAIN;
        cfg_wdata        <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.cmd        <= CMD_RUN;
        in_ch.err_sample <= '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_values();
        test_field_extremes();
        test_clear();
        test_inverted_limits();
        test_zero_integ_limit();
        test_output_hold();
        test_random_steps();

        in_ch.valid <= 1'b0;
        guard = 0;
        while (expected_drive.size() != 0 && guard < 100_000) begin
            @(negedge clk);
            guard++;
        end
        repeat (10) @(negedge clk);
        if (expected_drive.size() != 0) begin
            $display("%0d expected drive values never arrived", expected_drive.size());
            error_count++;
        end
        $display("covered %0d controller steps and %0d clears over %0d register settings",
                 step_count, clear_count, setting_count);
        $display("longest output hold-off %0d cycles, %0d mismatches", longest_hold, error_count);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/pidca_pkg.sv
hdl/pidca_in_if.sv
hdl/pidca_out_if.sv
hdl/pidca_front.sv
hdl/pidca_mult.sv
hdl/pidca_integ.sv
hdl/pidca_out.sv
hdl/pid_conditional_antiwindup_core.sv
tb/sv/pid_conditional_antiwindup_core_test.sv
